// ===== sv/csme_pkg.sv =====
// ----------------------------------------------------------------------------
// csme_pkg: shared types and constants for the CSR sparse matrix engine
// Operation codes, store geometry and Q16.16 helpers.
// ----------------------------------------------------------------------------
package csme_pkg;

  localparam int MaxRows     = 256;
  localparam int MaxNonzeros = 4096;
  localparam int RowW        = $clog2(MaxRows);
  localparam int SlotW       = $clog2(MaxNonzeros);

  localparam logic [3:0] OP_ROW_START = 4'd0;
  localparam logic [3:0] OP_ENTRY     = 4'd1;
  localparam logic [3:0] OP_X         = 4'd2;
  localparam logic [3:0] OP_RHS_WR    = 4'd3;
  localparam logic [3:0] OP_RHS_RD    = 4'd4;
  localparam logic [3:0] OP_ROW_MUL   = 4'd5;
  localparam logic [3:0] OP_LOOKUP    = 4'd6;
  localparam logic [3:0] OP_DIRICHLET = 4'd7;
  localparam logic [3:0] OP_ZERO      = 4'd8;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic        start;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] acc;
  } mac_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/csme_mac.sv =====
// ----------------------------------------------------------------------------
// csme_mac: shared Q16.16 multiply-accumulate unit
// Registered 32x32 product, then floor shift, saturate and saturating add.
// Start passes through busy to done; sum is valid while done is high.
// ----------------------------------------------------------------------------
module csme_mac (
  input  logic                   clk,
  input  logic                   rst,
  input  csme_pkg::mac_req_t     req,
  output logic                   done,
  output logic signed [31:0]     sum
);
  import csme_pkg::*;

  logic signed [63:0] prod;
  logic signed [31:0] acc_q;
  logic               busy;
  logic signed [47:0] shifted;
  logic signed [31:0] qv;

  always_ff @(posedge clk) begin
    prod  <= 64'(req.a) * 64'(req.b);
    acc_q <= req.acc;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= req.start;
      done <= busy;
    end
  end

  always_comb begin
    shifted = prod[63:16];
    if (shifted > 48'sd2147483647) begin
      qv = 32'sh7FFF_FFFF;
    end else if (shifted < -48'sd2147483648) begin
      qv = 32'sh8000_0000;
    end else begin
      qv = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    sum <= sat32(34'(acc_q) + 34'(qv));
  end
endmodule

// ===== sv/csr_sparse_matrix_engine_top.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matrix_engine_top: CSR sparse matrix engine
// Writes and the rhs read touch one store entry; row multiply walks the entries of a row
//   through the MAC; lookup walks them until the column matches; Dirichlet walks every
//   row, then the node row; zero clears the value store, one value slot per cycle.
// One item at a time: the next input beat can follow in the cycle after the result beat
// is taken.
// Reset clears control state and row_count to 1; stores stay undefined.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic [8:0]         index,
  input  logic [12:0]        slot,
  input  logic [7:0]         column,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic               found
);
  import csme_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RB    = 4'd1;
  localparam logic [3:0] S_RE    = 4'd2;
  localparam logic [3:0] S_ENT   = 4'd3;
  localparam logic [3:0] S_XRD   = 4'd4;
  localparam logic [3:0] S_MAC   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_RHS   = 4'd7;
  localparam logic [3:0] S_DMAC  = 4'd8;
  localparam logic [3:0] S_NODE  = 4'd9;
  localparam logic [3:0] S_ZERO  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_DNEXT = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [SlotW:0]        rs_mem [MaxRows+1];
  logic [7:0]            col_mem [MaxNonzeros];
  logic signed [31:0]    val_mem [MaxNonzeros];
  logic signed [31:0]    x_mem [MaxRows];
  logic signed [31:0]    rhs_mem [MaxRows];

  logic [3:0]            state;
  logic [8:0]            row_count;
  logic [3:0]            op_q;
  logic [8:0]            idx_q;
  logic [7:0]            col_q;
  logic signed [31:0]    val_q;
  logic [8:0]            r;
  logic                  node_pass;
  logic [SlotW:0]        j;
  logic [SlotW:0]        jend;
  logic [SlotW:0]        rs_rd;
  logic [7:0]            col_rd;
  logic signed [31:0]    ent_rd;
  logic signed [31:0]    x_rd;
  logic signed [31:0]    rhs_rd;
  logic signed [31:0]    acc;
  logic [8:0]            rows;
  mac_req_t              mreq;
  logic                  mdone;
  logic signed [31:0]    msum;
  logic [SlotW-1:0]      ja;
  logic [RowW-1:0]       x_addr;
  logic [8:0]            rs_addr;

  csme_mac u_mac (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .sum(msum));

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign rows     = (row_count > 9'(MaxRows)) ? 9'(MaxRows) : row_count;
  assign ja       = j[SlotW-1:0];
  assign x_addr   = col_rd[RowW-1:0];
  assign rs_addr  = (state == S_RB) ? r : 9'(r + 9'd1);

  always_ff @(posedge clk) begin
    rs_rd  <= rs_mem[rs_addr];
    col_rd <= col_mem[ja];
    ent_rd <= val_mem[ja];
    x_rd   <= x_mem[x_addr];
    rhs_rd <= rhs_mem[r[RowW-1:0]];
  end

  always_ff @(posedge clk) begin
    mreq.start <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      row_count <= 9'd1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_count <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_q         <= op;
            idx_q        <= index;
            col_q        <= column;
            val_q        <= value;
            result_value <= '0;
            found        <= 1'b0;
            acc          <= '0;
            node_pass    <= 1'b0;
            r            <= index;
            j            <= '0;
            state        <= S_OUT;
            unique case (op)
              OP_ROW_START: if (index <= 9'(MaxRows)) rs_mem[index] <= slot;
              OP_ENTRY: if (slot < 13'(MaxNonzeros)) begin
                col_mem[slot[SlotW-1:0]] <= column;
                val_mem[slot[SlotW-1:0]] <= value;
              end
              OP_X: if (index < 9'(MaxRows)) x_mem[index[RowW-1:0]] <= value;
              OP_RHS_WR: if (index < 9'(MaxRows)) rhs_mem[index[RowW-1:0]] <= value;
              OP_RHS_RD: if (index < 9'(MaxRows)) state <= S_WAIT;
              OP_ROW_MUL, OP_LOOKUP: if (index < 9'(MaxRows)) state <= S_RB;
              OP_DIRICHLET: begin
                r     <= '0;
                state <= (row_count == 9'd0) ? S_DNEXT : S_RB;
              end
              OP_ZERO: state <= S_ZERO;
              default: ;
            endcase
          end
        end
        S_WAIT: begin
          state <= S_RHS;
        end
        S_RHS: begin
          result_value <= rhs_rd;
          state        <= S_OUT;
        end
        S_RB: state <= S_RE;
        S_RE: begin
          j     <= rs_rd;
          state <= S_ENT;
        end
        S_ENT: begin
          jend  <= (rs_rd > (SlotW+1)'(MaxNonzeros)) ? (SlotW+1)'(MaxNonzeros) : rs_rd;
          state <= S_CHK;
        end
        S_CHK: begin
          if (j >= jend) begin
            state <= (op_q == OP_DIRICHLET) ? S_DNEXT : S_OUT;
            if (op_q == OP_ROW_MUL) result_value <= acc;
          end else begin
            state <= S_XRD;
          end
        end
        S_XRD: begin
          if (op_q == OP_ROW_MUL) begin
            state <= S_MAC;
          end else if (op_q == OP_LOOKUP) begin
            if (col_rd == col_q) begin
              result_value <= ent_rd;
              found        <= 1'b1;
              state        <= S_OUT;
            end else begin
              j     <= j + 1'b1;
              state <= S_CHK;
            end
          end else if (node_pass) begin
            val_mem[ja] <= ({1'b0, col_rd} == idx_q) ? Q_ONE : '0;
            j     <= j + 1'b1;
            state <= S_CHK;
          end else if ({1'b0, col_rd} == idx_q) begin
            val_mem[ja] <= '0;
            mreq.start  <= 1'b1;
            mreq.a      <= ent_rd;
            mreq.b      <= val_q;
            mreq.acc    <= rhs_rd;
            state       <= S_DMAC;
          end else begin
            j     <= j + 1'b1;
            state <= S_CHK;
          end
        end
        S_MAC: begin
          if (!mreq.start && !mdone) begin
            mreq.start <= 1'b1;
            mreq.a     <= ent_rd;
            mreq.b     <= x_rd;
            mreq.acc   <= acc;
          end
          if (mdone) begin
            acc   <= msum;
            j     <= j + 1'b1;
            state <= S_CHK;
          end
        end
        S_DMAC: begin
          if (mdone) begin
            rhs_mem[r[RowW-1:0]] <= msum;
            state <= S_DNEXT;
          end
        end
        S_DNEXT: begin
          if (!node_pass && (r + 9'd1 < rows)) begin
            r     <= r + 9'd1;
            state <= S_RB;
          end else if (!node_pass && idx_q < 9'(MaxRows)) begin
            node_pass <= 1'b1;
            r         <= idx_q;
            state     <= S_RB;
          end else begin
            state <= S_OUT;
          end
        end
        S_ZERO: begin
          val_mem[ja] <= '0;
          j <= j + 1'b1;
          if (ja == SlotW'(MaxNonzeros - 1)) state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
